>>> hdl/box_mean_filter_3x3_macros.svh
// assertion macros for the 3x3 box mean filter
`ifndef BOX_MEAN_FILTER_3X3_MACROS_SVH
`define BOX_MEAN_FILTER_3X3_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication under reset
`define BMF3_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmf3 check failed");
// next-cycle implication under reset
`define BMF3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmf3 check failed");
`else
`define BMF3_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BMF3_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/bmf3_pkg.sv
// shared types, constants and helpers for the 3x3 box mean filter
`timescale 1ns / 1ps

package bmf3_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int PIX_W   = 8;
  localparam int DIM_W   = 9;
  localparam int COORD_W = 8;
  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int SUM_W   = 12;
  localparam int MEAN_W  = 16;
  localparam int CFG_IDX_W = 1;

  // floor(y / 9) as (y * RECIP_9) >> RECIP_SHIFT, exact for y below 32768
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_9     = 14564;
  localparam int Y_W         = SUM_W + 2;
  localparam int PROD_W      = 2 * Y_W;
  localparam int QUO_W       = 10;

  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [MEAN_W-1:0]    mean_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_FRAME_WIDTH  = 1'b0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 1'b1;

  // position info that travels with a pixel
  typedef struct packed {
    coord_t row;
    coord_t col;
    logic   last;
  } meta_t;

  // limit a frame dimension to 3..hi
  function automatic dim_t clamp_dim(dim_t v, dim_t hi);
    dim_t res;
    if (v < dim_t'(3)) begin
      res = dim_t'(3);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

>>> hdl/bmf3_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module bmf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/box_mean_filter_3x3.sv
// out_valid rises after a transfer passes stage 1, window, sum, quotient and output.
// Throughput: one pixel per cycle when out_stall is low; line store ram is read on transfer
//   and written back as the pixel leaves the read stage, one access of each kind per cycle.
// Pixels at row < 2 or column < 2 produce no result.
// Reset (rst_n low, synchronous): counters, pipeline valids and the per-column
//   line valid bits clear, frame_width and frame_height return to 256.
`timescale 1ns / 1ps
`include "box_mean_filter_3x3_macros.svh"

module box_mean_filter_3x3 (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  bmf3_pkg::cfg_idx_t  cfg_index,
  input  bmf3_pkg::dim_t      cfg_wdata,
  // pixel input
  input  logic                in_valid,
  output logic                in_stall,
  input  bmf3_pkg::pix_t      in_pixel,
  // result output
  output logic                out_valid,
  input  logic                out_stall,
  output bmf3_pkg::mean_t     out_mean_q8,
  output bmf3_pkg::coord_t    out_row,
  output bmf3_pkg::coord_t    out_col,
  output logic                out_last_of_frame
);

  import bmf3_pkg::*;

  // config registers
  dim_t frame_width_r, frame_height_r;
  dim_t width_eff, height_eff;

  // raster counters
  coord_t col_r, row_r, col_nxt, row_nxt;
  logic   last_col, last_row, emit_now;

  // pipeline stages
  logic   v1_r, v2_r, v3_r, v4_r, vo_r;
  logic   rdy1, rdy2, rdy3, rdy4, rdyo;
  logic   in_xfer, mv1, mv2, mv3, mv4;
  meta_t  meta1_r, meta2_r, meta3_r, meta4_r;
  logic   emit1_r, emit2_r;
  pix_t   px1_r;
  sum_t   sum3_r, sum4_r;
  logic [QUO_W-1:0] quo4_r;

  // line store and window
  logic [2*PIX_W-1:0] ram_rdata, ram_wdata;
  logic [MAX_WIDTH-1:0] line_vld_r;
  pix_t top_px, mid_px;
  pix_t win_r [9];

  // datapath temporaries
  logic [PIX_W+1:0]   row_sum0, row_sum1, row_sum2;
  sum_t               win_sum;
  logic [Y_W-1:0]     y_val;
  logic [PROD_W-1:0]  prod;
  logic [MEAN_W:0]    mul28;
  mean_t              mean_nxt;

  // clamped frame size
  assign width_eff  = clamp_dim(frame_width_r, dim_t'(MAX_WIDTH));
  assign height_eff = clamp_dim(frame_height_r, dim_t'(MAX_HEIGHT));

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= dim_t'(MAX_WIDTH);
      frame_height_r <= dim_t'(MAX_HEIGHT);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ready chain from the output back to the input
  assign rdyo = !vo_r || !out_stall;
  assign rdy4 = !v4_r || rdyo;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_stall = !rdy1;
  assign in_xfer  = in_valid && rdy1;
  assign mv1      = v1_r && rdy2;
  assign mv2      = v2_r && rdy3;
  assign mv3      = v3_r && rdy4;
  assign mv4      = v4_r && rdyo;

  // raster position of the incoming pixel
  assign last_col = ({1'b0, col_r} + dim_t'(1)) >= width_eff;
  assign last_row = ({1'b0, row_r} + dim_t'(1)) >= height_eff;
  assign emit_now = (row_r >= coord_t'(2)) && (col_r >= coord_t'(2));

  always_comb begin
    col_nxt = col_r + coord_t'(1);
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + coord_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_xfer) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store: upper byte holds two rows up, lower byte one row up
  assign ram_wdata = {mid_px, px1_r};

  bmf3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (mv1),
    .waddr (meta1_r.col[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (col_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // columns never written read as zero
  assign top_px = line_vld_r[meta1_r.col[ADDR_W-1:0]] ? ram_rdata[2*PIX_W-1:PIX_W] : '0;
  assign mid_px = line_vld_r[meta1_r.col[ADDR_W-1:0]] ? ram_rdata[PIX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_vld_r <= '0;
    end else if (mv1) begin
      line_vld_r[meta1_r.col[ADDR_W-1:0]] <= 1'b1;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r && emit2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdyo) vo_r <= v4_r;
    end
  end

  // stage 1: pixel waits for its line store read
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      px1_r        <= in_pixel;
      meta1_r.row  <= row_r;
      meta1_r.col  <= col_r;
      meta1_r.last <= last_col && last_row;
      emit1_r      <= emit_now;
    end
  end

  // stage 2: window shifts in the new column
  always_ff @(posedge clk) begin
    if (mv1) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= top_px;
      win_r[5] <= mid_px;
      win_r[8] <= px1_r;
      meta2_r  <= meta1_r;
      emit2_r  <= emit1_r;
    end
  end

  // window sum as a small adder tree
  assign row_sum0 = {2'b0, win_r[0]} + {2'b0, win_r[1]} + {2'b0, win_r[2]};
  assign row_sum1 = {2'b0, win_r[3]} + {2'b0, win_r[4]} + {2'b0, win_r[5]};
  assign row_sum2 = {2'b0, win_r[6]} + {2'b0, win_r[7]} + {2'b0, win_r[8]};
  assign win_sum  = {2'b0, row_sum0} + {2'b0, row_sum1} + {2'b0, row_sum2};

  // stage 3: registered sum
  always_ff @(posedge clk) begin
    if (mv2) begin
      sum3_r  <= win_sum;
      meta3_r <= meta2_r;
    end
  end

  // 256*s/9 = 28*s + floor(4*s/9); the second term by reciprocal multiply
  assign y_val = {sum3_r, 2'b00};
  assign prod  = PROD_W'(y_val) * PROD_W'(RECIP_9);

  // stage 4: registered quotient
  always_ff @(posedge clk) begin
    if (mv3) begin
      sum4_r  <= sum3_r;
      quo4_r  <= prod[RECIP_SHIFT +: QUO_W];
      meta4_r <= meta3_r;
    end
  end

  assign mul28    = ((MEAN_W+1)'(sum4_r) << 5) - ((MEAN_W+1)'(sum4_r) << 2);
  assign mean_nxt = mul28[MEAN_W-1:0] + MEAN_W'(quo4_r);

  // output register
  always_ff @(posedge clk) begin
    if (mv4) begin
      out_mean_q8       <= mean_nxt;
      out_row           <= meta4_r.row;
      out_col           <= meta4_r.col;
      out_last_of_frame <= meta4_r.last;
    end
  end

  assign out_valid = vo_r;

  // line store write-back never hits the column being read in the same cycle
  `BMF3_ASSERT_NOW(a_no_ram_collision, clk, rst_n, mv1 && in_xfer, meta1_r.col != col_r)
  // the last pixel of a frame wraps both counters
  `BMF3_ASSERT_NEXT(a_frame_wrap, clk, rst_n, in_xfer && last_col && last_row,
    col_r == '0 && row_r == '0)
  // results only for complete windows
  `BMF3_ASSERT_NOW(a_full_window, clk, rst_n, vo_r,
    out_row >= coord_t'(2) && out_col >= coord_t'(2))

endmodule

>>> sim/box_mean_filter_3x3_checker.sv
// window mean predictor and result checker for the 3x3 box mean filter
`timescale 1ns / 1ps

module box_mean_filter_3x3_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  bmf3_pkg::cfg_idx_t cfg_index,
  input  bmf3_pkg::dim_t     cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  bmf3_pkg::pix_t     in_pixel,
  input  logic               out_valid,
  input  logic               out_stall,
  input  bmf3_pkg::mean_t    out_mean_q8,
  input  bmf3_pkg::coord_t   out_row,
  input  bmf3_pkg::coord_t   out_col,
  input  logic               out_last_of_frame,
  output int                 mismatches,
  output int                 means_in_flight
);
  import bmf3_pkg::*;

  localparam int WINDOW_TAPS = 9;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    mean_t  mean;
    coord_t row;
    coord_t col;
    logic   last;
  } window_mean_t;

  // shadow of the block state
  dim_t         width_reg;
  dim_t         height_reg;
  pix_t         upper_line [MAX_WIDTH];
  pix_t         middle_line [MAX_WIDTH];
  pix_t         window [WINDOW_TAPS];
  coord_t       col_cnt;
  coord_t       row_cnt;
  window_mean_t expected_means [$];

  initial begin
    mismatches      = 0;
    means_in_flight = 0;
  end

  // frame dimension as the block uses it
  function automatic dim_t limit_dim(dim_t raw, dim_t hi);
    dim_t v;
    v = raw;
    if (raw < dim_t'(3)) v = dim_t'(3);
    else if (raw > hi) v = hi;
    return v;
  endfunction

  // shift one pixel through line stores and window, queue the mean it yields
  task automatic slide_window(input pix_t px);
    dim_t              w;
    dim_t              h;
    pix_t              top;
    pix_t              mid;
    logic              last_col;
    logic              last_row;
    sum_t              sum;
    logic [SUM_W+7:0]  scaled;
    window_mean_t      res;
    w = limit_dim(width_reg, dim_t'(MAX_WIDTH));
    h = limit_dim(height_reg, dim_t'(MAX_HEIGHT));
    top = upper_line[col_cnt];
    mid = middle_line[col_cnt];
    upper_line[col_cnt]  = mid;
    middle_line[col_cnt] = px;
    for (int r = 0; r < 3; r++) begin
      window[r*3]   = window[r*3+1];
      window[r*3+1] = window[r*3+2];
    end
    window[2] = top;
    window[5] = mid;
    window[8] = px;
    last_col = ({1'b0, col_cnt} + dim_t'(1)) >= w;
    last_row = ({1'b0, row_cnt} + dim_t'(1)) >= h;
    // full window once two rows and two columns are behind us
    if (row_cnt >= coord_t'(2) && col_cnt >= coord_t'(2)) begin
      sum = '0;
      for (int k = 0; k < WINDOW_TAPS; k++) sum += sum_t'(window[k]);
      scaled   = {sum, 8'd0};
      res.mean = mean_t'(scaled / WINDOW_TAPS);
      res.row  = row_cnt;
      res.col  = col_cnt;
      res.last = last_col && last_row;
      expected_means.push_back(res);
    end
    // raster counters
    if (last_col) begin
      col_cnt = '0;
      row_cnt = last_row ? '0 : row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endtask

  task automatic log_fault(input string what, input window_mean_t want);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t result %s: got mean/row/col/last %0d/%0d/%0d/%0b, want %0d/%0d/%0d/%0b",
               $realtime, what, out_mean_q8, out_row, out_col, out_last_of_frame,
               want.mean, want.row, want.col, want.last);
    end
  endtask

  // compare one result transfer with the oldest queued mean
  task automatic check_result();
    window_mean_t want;
    if (expected_means.size() == 0) begin
      log_fault("with nothing pending", '0);
    end else begin
      want = expected_means.pop_front();
      if (out_mean_q8 !== want.mean || out_row !== want.row || out_col !== want.col ||
          out_last_of_frame !== want.last) begin
        log_fault("mismatch", want);
      end
    end
  endtask

  // watch config writes and both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = dim_t'(MAX_WIDTH);
      height_reg = dim_t'(MAX_HEIGHT);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < WINDOW_TAPS; i++) window[i] = '0;
      col_cnt = '0;
      row_cnt = '0;
      expected_means.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_reg = cfg_wdata;
          REG_FRAME_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) slide_window(in_pixel);
    end
    means_in_flight = expected_means.size();
  end

endmodule

>>> sim/box_mean_filter_3x3_tb.sv
// stimulus and verdict for the 3x3 box mean filter
`timescale 1ns / 1ps

module box_mean_filter_3x3_tb;
  import bmf3_pkg::*;

  localparam int RANDOM_PIXELS = 450;
  localparam int PACE_STEP     = 150;

  logic     clk;
  logic     rst_n;
  logic     cfg_wr_en;
  cfg_idx_t cfg_index;
  dim_t     cfg_wdata;
  logic     in_valid;
  logic     in_stall;
  pix_t     in_pixel;
  logic     out_valid;
  logic     out_stall;
  mean_t    out_mean_q8;
  coord_t   out_row;
  coord_t   out_col;
  logic     out_last_of_frame;
  int       mismatches;
  int       means_in_flight;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;

  box_mean_filter_3x3 i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mean_q8       (out_mean_q8),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_frame (out_last_of_frame)
  );

  box_mean_filter_3x3_checker i_mean_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mean_q8       (out_mean_q8),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_frame (out_last_of_frame),
    .mismatches        (mismatches),
    .means_in_flight   (means_in_flight)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("[box_mean_filter_3x3] ERROR");
    $finish;
  end

  // mostly uniform pixels, with extra weight on black and white
  function automatic pix_t pick_pixel();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return '0;
    if (roll < 30) return '1;
    return pix_t'($urandom);
  endfunction

  function automatic int eff_dim(int raw);
    if (raw < 3) return 3;
    if (raw > MAX_WIDTH) return MAX_WIDTH;
    return raw;
  endfunction

  // idle mix: receiver-heavy gaps, then sender-heavy, then none
  task automatic set_pace(input int mode);
    case (mode)
      0: begin tx_idle_pct = 36; rx_idle_pct = 53; end
      1: begin tx_idle_pct = 53; rx_idle_pct = 36; end
      default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
    endcase
  endtask

  // write both frame registers on back-to-back cycles
  task automatic write_frame(input dim_t width_raw, input dim_t height_raw);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= width_raw;
    @(negedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= height_raw;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // one pixel transfer, with random gaps in front
  task automatic send_pixel(input pix_t px);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop the stream and let every pending mean and the pipeline tail drain
  task automatic drain();
    int saved_rx;
    saved_rx = rx_idle_pct;
    in_valid <= 1'b0;
    rx_idle_pct = 0;
    while (means_in_flight != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    rx_idle_pct = saved_rx;
  endtask

  initial begin
    int  random_pixels;
    int  w_raw;
    int  h_raw;
    int  burst;
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_pixel  = '0;
    random_pixels = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_pace(0);

    // both dimensions below range act as 3, all-white window gives full scale
    write_frame(9'd0, 9'd2);
    repeat (9) send_pixel('1);
    drain();

    // frame started at 5 wide, narrowed to 3 mid-row with counter past the new end
    write_frame(9'd5, 9'd4);
    repeat (8) send_pixel('0);
    drain();
    write_frame(9'd3, 9'd300);
    repeat (5) send_pixel('0);
    drain();

    // random frames
    while (random_pixels < RANDOM_PIXELS) begin
      set_pace(random_pixels / PACE_STEP);
      if ($urandom_range(7) == 0) begin
        w_raw = $urandom_range(511);
        h_raw = $urandom_range(511);
        burst = $urandom_range(1, 40);
      end else begin
        w_raw = $urandom_range(12);
        h_raw = $urandom_range(8);
        if ($urandom_range(3) == 0) burst = $urandom_range(1, 40);
        else burst = eff_dim(w_raw) * eff_dim(h_raw) * $urandom_range(1, 2);
      end
      write_frame(dim_t'(w_raw), dim_t'(h_raw));
      repeat (burst) send_pixel(pick_pixel());
      random_pixels += burst;
      drain();
    end

    drain();
    if (mismatches == 0 && means_in_flight == 0) begin
      $display("[box_mean_filter_3x3] OK");
    end else begin
      $display("[box_mean_filter_3x3] ERROR");
    end
    $finish;
  end

endmodule
